[sv/b64e_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and the alphabet lookup for the base64 encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   localparam logic [7:0] PadChar = 8'h3D;

   // pending bit count carried between bytes
   typedef enum logic [1:0] {
      PH_0,
      PH_2,
      PH_4
   } b64e_phase_type;

   // one queue entry: the characters made by one byte
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
      logic            eom;
   } b64e_entry_type;

   typedef struct packed {
      logic           valid;
      b64e_entry_type entry;
   } b64e_slot_type;

   function automatic logic [7:0] b64e_sym(input logic [5:0] group);
      logic [7:0] g;
      logic [7:0] ch;
      g = {2'b00, group};
      case (group) inside
         [6'd0 : 6'd25]:  ch = 8'h41 + g;
         [6'd26 : 6'd51]: ch = 8'h61 + g - 8'd26;
         [6'd52 : 6'd61]: ch = 8'h30 + g - 8'd52;
         6'd62:           ch = 8'h2B;
         default:         ch = 8'h2F;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

[sv/base64_stream_encoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder
// padded base64 encoder, one message byte in, one ascii character out
// ----------------------------------------------------------------------------
// usage:
//   req_* carries message bytes, req_tlast marks the final byte of a message.
//   rsp_* carries ascii characters of the standard alphabet and '=' pads,
//   rsp_tlast marks the final character of the encoded message.
//   a byte that is accepted is written into the queue, and its first
//   character then passes through the output character register to rsp.
//   one character per cycle goes out while rsp_tready is high, set by the
//   single output character register; a byte gives one or two characters
//   (up to four for a final byte), so three bytes give four characters.
//   the front keeps the 0, 2 or 4 pending bits and pushes one word of
//   characters per byte into a four-deep queue, so bytes keep being taken
//   while the receiver stalls until that queue fills; rsp data holds still
//   while rsp_tvalid is high and rsp_tready is low.
//   reset (synchronous, active high) drops pending bits, empties the queue
//   and clears rsp_tvalid.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,    // [7:0] data_byte
   input  wire        req_tlast,    // last_byte
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_char
   output logic       rsp_tlast     // last_char
);
   import b64e_pkg::*;

   b64e_slot_type push;
   b64e_slot_type head;
   logic          q_full;
   logic          pop;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_data  (req_tdata),
      .byte_last  (req_tlast),
      .q_full     (q_full),
      .byte_ready (req_tready),
      .push       (push)
   );

   b64e_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_ready (rsp_tready)
   );

endmodule
`default_nettype wire

[sv/b64e_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front
// accepts message bytes, splits them into 6-bit groups, pushes char words
// ----------------------------------------------------------------------------
module b64e_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    byte_valid,
   input  wire  [7:0]             byte_data,
   input  wire                    byte_last,
   input  wire                    q_full,
   output logic                   byte_ready,
   output b64e_pkg::b64e_slot_type push
);
   import b64e_pkg::*;

   b64e_phase_type phase_ff, phase_in;
   logic [3:0]     bits_ff, bits_in;
   logic           take;

   assign byte_ready = !q_full;
   assign take       = byte_valid && !q_full;

   // next state
   always_comb begin
      phase_in = phase_ff;
      bits_in  = bits_ff;
      if (take) begin
         case (phase_ff)
            PH_2: begin
               phase_in = PH_4;
               bits_in  = byte_data[3:0];
            end
            PH_4: begin
               phase_in = PH_0;
               bits_in  = 4'd0;
            end
            default: begin
               phase_in = PH_2;
               bits_in  = {2'b00, byte_data[1:0]};
            end
         endcase
         if (byte_last) begin
            phase_in = PH_0;
            bits_in  = 4'd0;
         end
      end
   end

   // outputs
   always_comb begin
      push.valid          = take;
      push.entry.chars    = {PadChar, PadChar, PadChar, PadChar};
      push.entry.last_idx = 2'd0;
      push.entry.eom      = byte_last;
      case (phase_ff)
         PH_2: begin
            push.entry.chars[0] = b64e_sym({bits_ff[1:0], byte_data[7:4]});
            if (byte_last) begin
               push.entry.chars[1]  = b64e_sym({byte_data[3:0], 2'b00});
               push.entry.last_idx = 2'd2;
            end
         end
         PH_4: begin
            push.entry.chars[0] = b64e_sym({bits_ff, byte_data[7:6]});
            push.entry.chars[1] = b64e_sym(byte_data[5:0]);
            push.entry.last_idx = 2'd1;
         end
         default: begin
            push.entry.chars[0] = b64e_sym(byte_data[7:2]);
            if (byte_last) begin
               push.entry.chars[1]  = b64e_sym({byte_data[1:0], 4'b0000});
               push.entry.last_idx = 2'd3;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_0;
         bits_ff  <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         bits_ff  <= bits_in;
      end
   end

endmodule
`default_nettype wire

[sv/b64e_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_queue
// short fifo of char words between the front and the back
// ----------------------------------------------------------------------------
module b64e_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  b64e_pkg::b64e_slot_type push,
   input  wire                     pop,
   output logic                    full,
   output b64e_pkg::b64e_slot_type head
);
   import b64e_pkg::*;

   b64e_entry_type            slots_ff [QDepth];
   logic [QPtrW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]          cnt_ff, cnt_in;
   logic                      do_pop;

   assign full       = (cnt_ff == QCntW'(QDepth));
   assign head.valid = (cnt_ff != '0);
   assign head.entry = slots_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push.valid && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slots_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

[sv/b64e_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back
// walks char words to the output register, one char per cycle unless stalled
// ----------------------------------------------------------------------------
module b64e_back (
   input  wire                     clock,
   input  wire                     reset,
   input  b64e_pkg::b64e_slot_type head,
   output logic                    pop,
   output logic                    out_valid,
   output logic [7:0]              out_char,
   output logic                    out_last,
   input  wire                     out_ready
);
   import b64e_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       adv;
   logic       at_end;

   assign adv    = !valid_ff || out_ready;
   assign at_end = (idx_ff == head.entry.last_idx);
   assign pop    = adv && head.valid && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (adv) begin
         valid_in = head.valid;
         if (head.valid) begin
            char_in = head.entry.chars[idx_ff];
            last_in = head.entry.eom && at_end;
            idx_in  = at_end ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule
`default_nettype wire
